>>> rtl/tsri_pkg.sv
`default_nettype none
package tsri_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int LIMIT_W    = 11;
  localparam int LIMIT_RST  = 1024;
  localparam int NCHAN      = 9;
  localparam int CH_W       = 32;
  localparam int SIM_W      = 48;
  localparam int TIME_W     = 40;
  localparam int SIM_SPLIT  = 24;
  localparam int PW         = CH_W + 1 + FRAC_BITS + 1;
  localparam int FW         = SIM_W + 1 + FRAC_BITS + 1;
  localparam int STEP_W     = 5;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [TIME_W-1:0]        stamp_us;
    logic signed [SIM_W-1:0]  sim_time;
    logic signed [CH_W-1:0]   pos_x;
    logic signed [CH_W-1:0]   pos_y;
    logic signed [CH_W-1:0]   pos_z;
    logic signed [CH_W-1:0]   vel_x;
    logic signed [CH_W-1:0]   vel_y;
    logic signed [CH_W-1:0]   vel_z;
    logic signed [CH_W-1:0]   spin_x;
    logic signed [CH_W-1:0]   spin_y;
    logic signed [CH_W-1:0]   spin_z;
  } in_t;

  typedef struct packed {
    logic                     found;
    logic [TIME_W-1:0]        out_stamp_us;
    logic signed [SIM_W-1:0]  out_sim_time;
    logic signed [CH_W-1:0]   out_pos_x;
    logic signed [CH_W-1:0]   out_pos_y;
    logic signed [CH_W-1:0]   out_pos_z;
    logic signed [CH_W-1:0]   out_vel_x;
    logic signed [CH_W-1:0]   out_vel_y;
    logic signed [CH_W-1:0]   out_vel_z;
    logic signed [CH_W-1:0]   out_spin_x;
    logic signed [CH_W-1:0]   out_spin_y;
    logic signed [CH_W-1:0]   out_spin_z;
  } res_t;

  typedef logic [NCHAN-1:0][CH_W-1:0] vec_t;

  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [SIM_W-1:0]  sim;
    vec_t              vec;
  } row_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_START,
    OP_RECORD,
    OP_STOP,
    OP_QLOAD,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_RD_MID,
    OP_MID_STEP,
    OP_RD_LO,
    OP_LATCH_A,
    OP_LATCH_B,
    OP_DIV_STEP,
    OP_MUL_SIM_LO,
    OP_MUL,
    OP_ADD,
    OP_EMIT_ZERO,
    OP_EMIT_ROW,
    OP_EMIT_INTERP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] chan;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic t_le_rd;
    logic t_ge_rd;
    logic span_gt1;
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QCHK,
    S_FIRST,
    S_LAST,
    S_SRCH,
    S_CMP,
    S_GOTA,
    S_GOTB,
    S_DIV,
    S_MUL,
    S_MULH,
    S_ADD,
    S_EMIT,
    S_EMIT_ROW,
    S_EMIT_ZERO
  } state_t;

endpackage
`default_nettype wire

>>> rtl/tsri_dp.sv
`default_nettype none
module tsri_dp import tsri_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire in_t                in_data,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_data,
  output st_t                     st,
  output res_t                    res
);

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(RING_DEPTH)) s = s - (CNT_W+1)'(RING_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  logic [TIME_W-1:0] time_mem [RING_DEPTH];
  logic [SIM_W-1:0]  sim_mem  [RING_DEPTH];
  vec_t              vec_mem  [RING_DEPTH];

  logic [LIMIT_W-1:0] limit_r;
  logic               rec_r;
  logic [TIME_W-1:0]  start_r;
  logic [IDX_W-1:0]   oldest_r;
  logic [CNT_W-1:0]   count_r;
  logic [TIME_W-1:0]  t_r;
  logic [IDX_W-1:0]   lo_r, hi_r;
  row_t               rd_r, a_r, b_r;
  logic [TIME_W:0]    rem_r;
  logic [TIME_W-1:0]  dv_r;
  logic [FRAC_BITS-1:0] u_r;
  logic signed [PW-1:0] prod_r, plo_r;
  logic [SIM_W-1:0]   sim_acc_r;
  vec_t               vacc_r;
  res_t               out_r;

  logic [CNT_W-1:0]   lim, keep, drop;
  logic [IDX_W-1:0]   oldest_ev, rec_slot, wr_slot, rd_addr, mid;
  logic               wr_en, rd_en;
  logic [TIME_W-1:0]  rel, wr_time;
  vec_t               in_vec;
  logic signed [SIM_W:0] sim_d;
  logic signed [CH_W:0]  vd [NCHAN];
  logic signed [CH_W:0]  mul_a;
  logic signed [PW-1:0]  mul_p;
  logic [3:0]            cidx;
  logic [TIME_W:0]       rem2;
  logic signed [FW-1:0]  full_hi, full_lo, full_sum, full_sh;
  logic signed [PW-1:0]  vsh;

  // limit clamp and overwrite of the oldest entries
  always_comb begin
    if (limit_r == '0) lim = CNT_W'(1);
    else if (32'(limit_r) > 32'(RING_DEPTH)) lim = CNT_W'(RING_DEPTH);
    else lim = CNT_W'(limit_r);
    if (count_r >= lim) begin
      keep      = lim - CNT_W'(1);
      drop      = count_r - keep;
      oldest_ev = ring_add(oldest_r, drop);
    end else begin
      keep      = count_r;
      drop      = '0;
      oldest_ev = oldest_r;
    end
    rec_slot = ring_add(oldest_ev, keep);
    rel = (in_data.stamp_us >= start_r) ? in_data.stamp_us - start_r : '0;
  end

  assign in_vec[0] = in_data.pos_x;
  assign in_vec[1] = in_data.pos_y;
  assign in_vec[2] = in_data.pos_z;
  assign in_vec[3] = in_data.vel_x;
  assign in_vec[4] = in_data.vel_y;
  assign in_vec[5] = in_data.vel_z;
  assign in_vec[6] = in_data.spin_x;
  assign in_vec[7] = in_data.spin_y;
  assign in_vec[8] = in_data.spin_z;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    wr_en   = 1'b0;
    wr_slot = rec_slot;
    wr_time = rel;
    rd_en   = 1'b1;
    rd_addr = ring_add(oldest_r, CNT_W'(lo_r));
    case (cmd.op)
      OP_START: begin
        wr_en   = 1'b1;
        wr_slot = '0;
        wr_time = '0;
        rd_en   = 1'b0;
      end
      OP_RECORD: begin
        wr_en = rec_r;
        rd_en = 1'b0;
      end
      OP_RD_FIRST: rd_addr = oldest_r;
      OP_RD_LAST:  rd_addr = ring_add(oldest_r, count_r - CNT_W'(1));
      OP_RD_MID:   rd_addr = ring_add(oldest_r, CNT_W'(mid));
      OP_RD_LO:    rd_addr = ring_add(oldest_r, CNT_W'(lo_r));
      OP_LATCH_A:  rd_addr = ring_add(oldest_r, CNT_W'(hi_r));
      default:     rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_slot] <= wr_time;
      sim_mem[wr_slot]  <= in_data.sim_time;
      vec_mem[wr_slot]  <= in_vec;
    end
    if (rd_en) begin
      rd_r.tstamp <= time_mem[rd_addr];
      rd_r.sim    <= sim_mem[rd_addr];
      rd_r.vec    <= vec_mem[rd_addr];
    end
  end

  // channel differences and the shared multiplier
  // sim difference goes in two halves: low 24 bits unsigned, then the signed rest
  assign sim_d = $signed({a_r.sim[SIM_W-1], a_r.sim});
  always_comb begin
    logic signed [SIM_W:0] sb;
    logic signed [SIM_W:0] sdiff;
    sb    = $signed({b_r.sim[SIM_W-1], b_r.sim});
    sdiff = sb - sim_d;
    for (int i = 0; i < NCHAN; i++) begin
      vd[i] = $signed({b_r.vec[i][CH_W-1], b_r.vec[i]}) -
              $signed({a_r.vec[i][CH_W-1], a_r.vec[i]});
    end
    cidx = cmd.chan - 4'd1;
    case (cmd.op)
      OP_MUL_SIM_LO: mul_a = $signed({{(CH_W+1-SIM_SPLIT){1'b0}},
                                      sdiff[SIM_SPLIT-1:0]});
      default: begin
        if (cmd.chan == 4'd0) begin
          mul_a = (CH_W+1)'(sdiff >>> SIM_SPLIT);
        end else if (cidx < 4'(NCHAN)) begin
          mul_a = vd[cidx];
        end else begin
          mul_a = '0;
        end
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'($signed({1'b0, u_r}));

  always_comb begin
    full_hi  = FW'(prod_r) <<< SIM_SPLIT;
    full_lo  = FW'(plo_r);
    full_sum = full_hi + full_lo;
    full_sh  = full_sum >>> FRAC_BITS;
    vsh      = prod_r >>> FRAC_BITS;
    rem2     = {rem_r[TIME_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_W'(LIMIT_RST);
      rec_r    <= 1'b0;
      start_r  <= '0;
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      case (cmd.op)
        OP_START: begin
          count_r  <= CNT_W'(1);
          oldest_r <= '0;
          start_r  <= in_data.stamp_us;
          rec_r    <= 1'b1;
        end
        OP_RECORD: begin
          if (rec_r) begin
            oldest_r <= oldest_ev;
            count_r  <= keep + CNT_W'(1);
          end
        end
        OP_STOP: rec_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_QLOAD: begin
        t_r  <= in_data.stamp_us;
        lo_r <= '0;
        hi_r <= IDX_W'(count_r - CNT_W'(1));
      end
      OP_MID_STEP: begin
        if (rd_r.tstamp <= t_r) lo_r <= mid;
        else hi_r <= mid;
      end
      OP_LATCH_A: a_r <= rd_r;
      OP_LATCH_B: begin
        b_r   <= rd_r;
        rem_r <= {1'b0, t_r - a_r.tstamp};
        dv_r  <= rd_r.tstamp - a_r.tstamp;
        u_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem2 >= {1'b0, dv_r}) begin
          rem_r <= rem2 - {1'b0, dv_r};
          u_r   <= {u_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem2;
          u_r   <= {u_r[FRAC_BITS-2:0], 1'b0};
        end
      end
      OP_MUL_SIM_LO: plo_r <= mul_p;
      OP_MUL:        prod_r <= mul_p;
      OP_ADD: begin
        if (cmd.chan == 4'd0) begin
          sim_acc_r <= a_r.sim + full_sh[SIM_W-1:0];
        end else if (cidx < 4'(NCHAN)) begin
          vacc_r[cidx] <= a_r.vec[cidx] + vsh[CH_W-1:0];
        end
      end
      OP_EMIT_ZERO: out_r <= '0;
      OP_EMIT_ROW: begin
        out_r.found        <= 1'b1;
        out_r.out_stamp_us <= rd_r.tstamp;
        out_r.out_sim_time <= rd_r.sim;
        out_r.out_pos_x    <= rd_r.vec[0];
        out_r.out_pos_y    <= rd_r.vec[1];
        out_r.out_pos_z    <= rd_r.vec[2];
        out_r.out_vel_x    <= rd_r.vec[3];
        out_r.out_vel_y    <= rd_r.vec[4];
        out_r.out_vel_z    <= rd_r.vec[5];
        out_r.out_spin_x   <= rd_r.vec[6];
        out_r.out_spin_y   <= rd_r.vec[7];
        out_r.out_spin_z   <= rd_r.vec[8];
      end
      OP_EMIT_INTERP: begin
        out_r.found        <= 1'b1;
        out_r.out_stamp_us <= t_r;
        out_r.out_sim_time <= sim_acc_r;
        out_r.out_pos_x    <= vacc_r[0];
        out_r.out_pos_y    <= vacc_r[1];
        out_r.out_pos_z    <= vacc_r[2];
        out_r.out_vel_x    <= vacc_r[3];
        out_r.out_vel_y    <= vacc_r[4];
        out_r.out_vel_z    <= vacc_r[5];
        out_r.out_spin_x   <= vacc_r[6];
        out_r.out_spin_y   <= vacc_r[7];
        out_r.out_spin_z   <= vacc_r[8];
      end
      default: ;
    endcase
  end

  assign st.cnt_zero = (count_r == '0);
  assign st.cnt_one  = (count_r == CNT_W'(1));
  assign st.t_le_rd  = (t_r <= rd_r.tstamp);
  assign st.t_ge_rd  = (t_r >= rd_r.tstamp);
  assign st.span_gt1 = ((hi_r - lo_r) > IDX_W'(1));
  assign res = out_r;

endmodule
`default_nettype wire

>>> rtl/tsri_ctrl.sv
`default_nettype none
module tsri_ctrl import tsri_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_req,
  input  wire logic       out_stall,
  input  wire st_t        st,
  output logic            in_stall,
  output logic            out_valid,
  output cmd_t            cmd
);

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.op        = OP_IDLE;
    cmd.chan      = cnt_r[3:0];
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req)
            REQ_RECORD: cmd.op = OP_RECORD;
            REQ_START:  cmd.op = OP_START;
            REQ_STOP:   cmd.op = OP_STOP;
            default: begin
              cmd.op    = OP_QLOAD;
              state_nxt = S_QCHK;
            end
          endcase
        end
      end
      S_QCHK: begin
        if (st.cnt_zero) begin
          state_nxt = S_EMIT_ZERO;
        end else begin
          cmd.op    = OP_RD_FIRST;
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (st.cnt_one || st.t_le_rd) begin
          state_nxt = S_EMIT_ROW;
        end else begin
          cmd.op    = OP_RD_LAST;
          state_nxt = S_LAST;
        end
      end
      S_LAST: state_nxt = st.t_ge_rd ? S_EMIT_ROW : S_SRCH;
      S_SRCH: begin
        if (st.span_gt1) begin
          cmd.op    = OP_RD_MID;
          state_nxt = S_CMP;
        end else begin
          cmd.op    = OP_RD_LO;
          state_nxt = S_GOTA;
        end
      end
      S_CMP: begin
        cmd.op    = OP_MID_STEP;
        state_nxt = S_SRCH;
      end
      S_GOTA: begin
        cmd.op    = OP_LATCH_A;
        state_nxt = S_GOTB;
      end
      S_GOTB: begin
        cmd.op    = OP_LATCH_B;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt_r == STEP_W'(FRAC_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      S_MUL: begin
        if (cnt_r == '0) begin
          cmd.op    = OP_MUL_SIM_LO;
          state_nxt = S_MULH;
        end else begin
          cmd.op    = OP_MUL;
          state_nxt = S_ADD;
        end
      end
      S_MULH: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.op = OP_ADD;
        if (cnt_r == STEP_W'(NCHAN)) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + STEP_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_EMIT, S_EMIT_ROW, S_EMIT_ZERO: begin
        if (out_free) begin
          case (state_r)
            S_EMIT:     cmd.op = OP_EMIT_INTERP;
            S_EMIT_ROW: cmd.op = OP_EMIT_ROW;
            default:    cmd.op = OP_EMIT_ZERO;
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT_INTERP || cmd.op == OP_EMIT_ROW || cmd.op == OP_EMIT_ZERO)
      |-> out_free)
    else $error("result emitted over an untaken beat");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req == REQ_QUERY) |=> in_stall)
    else $error("query did not hold off the input");
  a_short_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req != REQ_QUERY) |=> !in_stall)
    else $error("non query request left block busy");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < STEP_W'(FRAC_BITS)))
    else $error("divider step count overrun");
`endif

endmodule
`default_nettype wire

>>> rtl/timestamped_sample_ring_interp.sv
// timestamped sample ring with interpolated readback
// input channel: in_valid / in_stall / in_data, one beat per request;
//   record and stop are done in the cycle they are taken, start clears the
//   ring and stores the first sample in that same cycle
// query: clamps to the ring ends, binary-searches the bracket through the
//   single registered memory read port, runs a restoring divider for the
//   weight and one shared 33x17 multiplier over the ten channels
// exactly one result beat per query, none for other requests
// input is stalled while a query is in flight
// out_valid / out_stall / out_data: the result sits in an output register;
//   while the receiver stalls it holds, and the next request is still taken,
//   only a later query result waits for the register to free up
// cfg_valid / cfg_ready: sample_limit write, always ready, write while idle
// reset (rst_n low, synchronous): ring empty, recording off, limit 1024;
//   sample memories are not cleared and need no sweep
`default_nettype none
module timestamped_sample_ring_interp import tsri_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire in_t                in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output res_t                    out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  // command and status between controller and datapath
  cmd_t cmd;
  st_t  st;

  // config write port never back-pressures
  assign cfg_ready = 1'b1;

  tsri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_data.req_type),
    .out_stall (out_stall),
    .st        (st),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  tsri_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .st       (st),
    .res      (out_data)
  );

endmodule
`default_nettype wire
